### src/cbf_pkg.sv
// Shared constants, payload types and divider constants for the centered box filter.
// No dependencies; every other source file except cbf_ram imports this package.
package cbf_pkg;

    localparam int RADIUS      = 8;
    localparam int SAMPLE_BITS = 16;

    localparam int WIN_LEN    = 2 * RADIUS + 1;
    localparam int PTR_BITS   = $clog2(WIN_LEN);
    localparam int SEEN_BITS  = $clog2(RADIUS + 2);
    localparam int FLUSH_BITS = $clog2(RADIUS + 1);
    localparam int SUM_BITS   = SAMPLE_BITS + $clog2(WIN_LEN);

    // Exact reciprocal for dividing a SUM_BITS magnitude by WIN_LEN:
    // q = (mag * RECIP) >> DIV_SHIFT, exact because the rounding error of
    // RECIP times any magnitude stays below 2**DIV_SHIFT.
    localparam int DIV_SHIFT  = SUM_BITS + $clog2(WIN_LEN);
    localparam int RECIP_BITS = SUM_BITS + 1;
    localparam int PROD_BITS  = SUM_BITS + RECIP_BITS;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << DIV_SHIFT) + 64'(WIN_LEN) - 64'd1) / 64'(WIN_LEN);
    localparam logic [RECIP_BITS-1:0] RECIP = RECIP_BITS'(RECIP_FULL);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last;
    } cbf_in_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] average;
        logic                          final_res;
    } cbf_out_t;

    // Window sum handed to the divider, with its end-of-sequence flag
    typedef struct packed {
        logic signed [SUM_BITS-1:0] sum;
        logic                       fin;
    } cbf_sum_t;

endpackage

### src/centered_box_filter.sv
// Top level of the centered box filter: window RAM, running sum and flush sequencing.
// Depends on cbf_pkg, cbf_ram and cbf_div.
//
//   port group   dir  handshake            payload
//   s_*          in   s_valid / s_ready    s_data  (cbf_in_t: sample, last)
//   m_*          out  m_valid / m_ready    m_data  (cbf_out_t: average, final_res)
//
// One sample is taken per cycle while s_ready is high; each one is a read-modify-write of one window
// RAM entry plus an update of the running sum.
// A request marked last is followed by RADIUS zero-sample shifts with s_ready low;
// each result is registered in p1_reg, then in the divider's product and output registers.
// Reset and end of sequence clear the per-entry valid bits at once: no clearing pass.
// A stalled m_ready backs up through the divider and then holds s_ready low.
module centered_box_filter import cbf_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  cbf_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output cbf_out_t m_data
);

    localparam logic [SEEN_BITS-1:0]  SEEN_FULL  = SEEN_BITS'(RADIUS + 1);
    localparam logic [FLUSH_BITS-1:0] FLUSH_ALL  = FLUSH_BITS'(RADIUS);
    localparam logic [FLUSH_BITS-1:0] FLUSH_ONE  = FLUSH_BITS'(1);
    localparam logic [PTR_BITS-1:0]   PTR_LAST   = PTR_BITS'(WIN_LEN - 1);

    logic signed [SUM_BITS-1:0]   sum_reg, sum_next;
    logic [SEEN_BITS-1:0]         seen_reg, seen_next;
    logic [FLUSH_BITS-1:0]        flush_left_reg, flush_left_next;
    logic [PTR_BITS-1:0]          ptr_reg, ptr_next;
    logic [WIN_LEN-1:0]           valid_reg, valid_next;
    logic                         p1_valid_reg, p1_valid_next;
    cbf_sum_t                     p1_reg, p1_next;

    logic                         flushing, p1_free, div_ready;
    logic                         step_in, step_flush, step, emit, fin, done;
    logic signed [SAMPLE_BITS-1:0] x, oldest;
    logic [SAMPLE_BITS-1:0]       ram_q;
    logic [PTR_BITS-1:0]          ptr_inc, rd_addr;
    logic signed [SUM_BITS-1:0]   sum_step;
    logic [SEEN_BITS-1:0]         seen_inc;

    assign flushing   = (flush_left_reg != '0);
    assign p1_free    = !p1_valid_reg || div_ready;
    assign s_ready    = !flushing && p1_free;
    assign step_in    = s_valid && s_ready;
    assign step_flush = flushing && p1_free;
    assign step       = step_in || step_flush;
    assign fin        = flushing && (flush_left_reg == FLUSH_ONE);
    assign done       = step_flush && fin;

    always_comb begin
        x        = flushing ? '0 : s_data.sample;
        // Entries never written since the last clear read as zero
        oldest   = valid_reg[ptr_reg] ? $signed(ram_q) : '0;
        sum_step = sum_reg + SUM_BITS'(x) - SUM_BITS'(oldest);
        seen_inc = (seen_reg == SEEN_FULL) ? seen_reg : seen_reg + 1'b1;
        emit     = step && (seen_inc == SEEN_FULL);
        ptr_inc  = (ptr_reg == PTR_LAST) ? '0 : ptr_reg + 1'b1;
        // Prefetch the next oldest entry so it is ready when the next shift comes
        rd_addr  = step ? ptr_inc : ptr_reg;

        sum_next        = sum_reg;
        seen_next       = seen_reg;
        flush_left_next = flush_left_reg;
        ptr_next        = ptr_reg;
        valid_next      = valid_reg;
        if (done) begin
            sum_next        = '0;
            seen_next       = '0;
            flush_left_next = '0;
            ptr_next        = '0;
            valid_next      = '0;
        end else if (step) begin
            sum_next            = sum_step;
            seen_next           = seen_inc;
            ptr_next            = ptr_inc;
            valid_next[ptr_reg] = 1'b1;
            if (step_in) begin
                flush_left_next = s_data.last ? FLUSH_ALL : '0;
            end else begin
                flush_left_next = flush_left_reg - 1'b1;
            end
        end

        p1_valid_next = p1_valid_reg;
        p1_next       = p1_reg;
        if (p1_free) begin
            p1_valid_next = emit;
            p1_next.sum   = sum_step;
            p1_next.fin   = fin;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg        <= '0;
            seen_reg       <= '0;
            flush_left_reg <= '0;
            ptr_reg        <= '0;
            valid_reg      <= '0;
            p1_valid_reg   <= 1'b0;
        end else begin
            sum_reg        <= sum_next;
            seen_reg       <= seen_next;
            flush_left_reg <= flush_left_next;
            ptr_reg        <= ptr_next;
            valid_reg      <= valid_next;
            p1_valid_reg   <= p1_valid_next;
        end
        p1_reg <= p1_next;
    end

    cbf_ram #(
        .WIDTH(SAMPLE_BITS),
        .DEPTH(WIN_LEN)
    ) u_window_ram (
        .aclk    (aclk),
        .wr_en   (step),
        .wr_addr (ptr_reg),
        .wr_data (x),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    cbf_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (p1_valid_reg),
        .in_ready (div_ready),
        .in_data  (p1_reg),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

### src/cbf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module cbf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 17
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### src/cbf_div.sv
// Divide-by-window-length pipeline: reciprocal multiply stage and output register.
// Depends on cbf_pkg.
module cbf_div import cbf_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  cbf_sum_t in_data,
    output logic     m_valid,
    input  logic     m_ready,
    output cbf_out_t m_data
);

    logic                  prod_valid_reg, prod_valid_next;
    logic [PROD_BITS-1:0]  prod_reg, prod_next;
    logic                  neg_reg, neg_next;
    logic                  fin_reg, fin_next;
    logic                  out_valid_reg, out_valid_next;
    cbf_out_t              out_reg, out_next;

    logic                  out_free;
    logic [SUM_BITS-1:0]   mag;
    logic [SAMPLE_BITS-1:0] quot;

    assign out_free = !out_valid_reg || m_ready;
    assign in_ready = !prod_valid_reg || out_free;

    always_comb begin
        mag  = in_data.sum[SUM_BITS-1] ? SUM_BITS'(-in_data.sum) : SUM_BITS'(in_data.sum);
        quot = prod_reg[DIV_SHIFT +: SAMPLE_BITS];

        prod_valid_next = prod_valid_reg;
        prod_next       = prod_reg;
        neg_next        = neg_reg;
        fin_next        = fin_reg;
        if (in_ready) begin
            prod_valid_next = in_valid;
            prod_next       = PROD_BITS'(mag) * PROD_BITS'(RECIP);
            neg_next        = in_data.sum[SUM_BITS-1];
            fin_next        = in_data.fin;
        end

        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_free) begin
            out_valid_next    = prod_valid_reg;
            out_next.average  = neg_reg ? SAMPLE_BITS'(-quot) : quot;
            out_next.final_res = fin_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            prod_valid_reg <= prod_valid_next;
            out_valid_reg  <= out_valid_next;
        end
        prod_reg <= prod_next;
        neg_reg  <= neg_next;
        fin_reg  <= fin_next;
        out_reg  <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

### src/cbf_checker.sv
// Port-level checker for the centered box filter, bound to the top level.
// Depends on cbf_pkg and centered_box_filter.
module cbf_checker import cbf_pkg::*; (
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input cbf_in_t  s_data,
    input logic     m_valid,
    input logic     m_ready,
    input cbf_out_t m_data
);

    // Hold a stalled result
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // The flush of a sequence blocks the next request
    a_flush_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.last |=> !s_ready)
        else $error("request taken during flush");

endmodule

bind centered_box_filter cbf_checker u_cbf_checker (.*);

### dv/centered_box_filter_test.sv
// Self-checking testbench for centered_box_filter: sends sample sequences and
// predicts each windowed average from its own copy of the window and running sum.
// Depends on cbf_pkg and the centered_box_filter RTL.
module centered_box_filter_test;
    import cbf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 20;

    typedef enum int {PAT_MIX, PAT_MAX, PAT_MIN, PAT_ALT} run_pattern_t;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    cbf_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    cbf_out_t m_data;

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int mismatch_count = 0;

    // Filter state as seen by the predictor
    int win_hist [WIN_LEN];
    int win_total;
    int fill_count;

    cbf_out_t avg_queue [$];

    centered_box_filter dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    function automatic void clear_window();
        foreach (win_hist[i]) win_hist[i] = 0;
        win_total  = 0;
        fill_count = 0;
    endfunction

    function automatic void shift_window(int x);
        win_total += x - win_hist[0];
        for (int i = 0; i < WIN_LEN - 1; i++) win_hist[i] = win_hist[i + 1];
        win_hist[WIN_LEN - 1] = x;
    endfunction

    function automatic void push_average(logic fin);
        cbf_out_t r;
        r.average   = SAMPLE_BITS'(win_total / WIN_LEN);
        r.final_res = fin;
        avg_queue.push_back(r);
    endfunction

    function automatic void predict_averages(cbf_in_t req);
        int pending;
        shift_window(int'(req.sample));
        if (fill_count < RADIUS + 1) fill_count++;
        if (!req.last) begin
            if (fill_count == RADIUS + 1) push_average(1'b0);
            return;
        end
        // pad a short sequence up to center 0, then flush the pending centers
        for (int pad = RADIUS + 1 - fill_count; pad > 0; pad--) shift_window(0);
        pending = fill_count;
        while (pending > 0) begin
            push_average(pending == 1);
            pending--;
            if (pending > 0) shift_window(0);
        end
        clear_window();
    endfunction

    // Compare every accepted result against the oldest expected average
    always @(posedge aclk) begin
        cbf_out_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (avg_queue.size() == 0) begin
                $display("%0t: unexpected result average=%0d final_res=%0b",
                         $time, m_data.average, m_data.final_res);
                mismatch_count++;
            end else begin
                exp_r = avg_queue.pop_front();
                if (m_data.average !== exp_r.average) begin
                    $display("%0t: average mismatch: expected %0d, got %0d",
                             $time, exp_r.average, m_data.average);
                    mismatch_count++;
                end
                if (m_data.final_res !== exp_r.final_res) begin
                    $display("%0t: final_res mismatch: expected %0b, got %0b",
                             $time, exp_r.final_res, m_data.final_res);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("centered_box_filter_test: done, errors");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_sample(logic signed [SAMPLE_BITS-1:0] smp, logic lst);
        cbf_in_t req;
        req.sample = smp;
        req.last   = lst;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            s_data  <= cbf_in_t'((SAMPLE_BITS + 1)'($urandom));
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        predict_averages(req);
        @(negedge aclk);
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(run_pattern_t pat, int idx);
        case (pat)
            PAT_MAX: return 16'sh7fff;
            PAT_MIN: return 16'sh8000;
            PAT_ALT: return idx[0] ? 16'sh8000 : 16'sh7fff;
            default: begin
                case ($urandom_range(0, 5))
                    0:       return 16'sh7fff;
                    1:       return 16'sh8000;
                    2:       return SAMPLE_BITS'(int'($urandom_range(0, 64)) - 32);
                    default: return SAMPLE_BITS'($urandom);
                endcase
            end
        endcase
    endfunction

    task automatic send_sequence(int len, run_pattern_t pat);
        for (int i = 0; i < len; i++) send_sample(pick_sample(pat, i), i == len - 1);
    endtask

    task automatic hold_idle();
        s_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        while (avg_queue.size() != 0) @(negedge aclk);
    endtask

    // Single sample, short runs at and below RADIUS, and the first full center
    task automatic test_sequence_edges();
        send_sequence(1, PAT_MIN);
        send_sequence(2, PAT_MAX);
        send_sequence(RADIUS, PAT_MAX);
        send_sequence(RADIUS + 1, PAT_ALT);
        send_sequence(3, PAT_MIX);
    endtask

    task automatic test_random_traffic(int src_pct, int sink_pct, int n_items);
        int sent;
        int len;
        run_pattern_t pat;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        sent = 0;
        while (sent < n_items) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 45)
                                              : $urandom_range(1, 24);
            case ($urandom_range(0, 9))
                0:       pat = PAT_MAX;
                1:       pat = PAT_MIN;
                2:       pat = PAT_ALT;
                default: pat = PAT_MIX;
            endcase
            if (pat != PAT_MIX && len < WIN_LEN && $urandom_range(0, 1))
                len = WIN_LEN + $urandom_range(0, 4);
            send_sequence(len, pat);
            sent += len;
        end
    endtask

    // Hold the sender until the previous sequence has fully drained
    task automatic test_pause_until_drained();
        src_idle_pct   = 0;
        sink_stall_pct = 24;
        send_sequence(12, PAT_MIX);
        hold_idle();
        wait_drained();
        send_sequence(WIN_LEN, PAT_MAX);
    endtask

    initial begin
        clear_window();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_sequence_edges();
        test_random_traffic(0, 0, 30);
        test_random_traffic(63, 0, 30);
        test_random_traffic(0, 63, 30);
        test_pause_until_drained();
        test_random_traffic(24, 24, 30);

        hold_idle();
        wait_drained();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (mismatch_count == 0 && avg_queue.size() == 0)
            $display("centered_box_filter_test: done, clean");
        else
            $display("centered_box_filter_test: done, errors");
        $finish;
    end

endmodule

### filelist.f
src/cbf_pkg.sv
src/cbf_ram.sv
src/cbf_div.sv
src/centered_box_filter.sv
src/cbf_checker.sv
dv/centered_box_filter_test.sv
